// ===== rtl/flash_log_ring_appender_assert.svh =====
// Assertion macros shared by the flash log ring appender RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FLASH_LOG_RING_APPENDER_ASSERT_SVH
`define FLASH_LOG_RING_APPENDER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define FLRA_ASSERT_ALWAYS(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FLRA_ASSERT_IMPLIES(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define FLRA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/flra_pkg.sv =====
// Package for the flash log ring appender: field widths, command codes,
// job descriptor passed from front end to back end. No dependencies.
package flra_pkg;

    localparam int LEN_W       = 12;
    localparam int ADDR_W      = 32;
    localparam int SEQ_W       = 32;
    localparam int PAGE_MAX_W  = 8;
    localparam int OFF_MAX_W   = 17;
    localparam int HDR_BYTES   = 4;
    localparam int FIFO_DEPTH  = 2;
    localparam int CFG_ADDR_W  = 2;

    localparam int DEF_PAGES      = 4;
    localparam int DEF_PAGE_BYTES = 4096;

    localparam logic [CFG_ADDR_W-1:0] REG_REGION_BASE = 2'd0;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_FORMAT = 1'b1;

    localparam logic [SEQ_W-1:0] RESET_SEQ  = 32'd2;
    localparam logic [SEQ_W-1:0] FORMAT_SEQ = 32'd1;

    typedef enum logic [1:0] {
        CMD_ERASE  = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_DATA   = 2'd2,
        CMD_REJECT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        JOB_DATA   = 2'd0,
        JOB_WRAP   = 2'd1,
        JOB_FORMAT = 2'd2,
        JOB_REJECT = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t              kind;
        logic [PAGE_MAX_W-1:0]  page;
        logic [SEQ_W-1:0]       seq;
        logic [OFF_MAX_W-1:0]   off;
        logic [LEN_W-1:0]       len;
    } job_t;

endpackage

// ===== rtl/flra_front.sv =====
// Front end: accepts requests, checks length, tracks page/offset/sequence
// and hands one job descriptor per request to the queue. Uses flra_pkg.
`include "flash_log_ring_appender_assert.svh"
module flra_front import flra_pkg::*; #(
    parameter int PAGES      = DEF_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             req_type,
    input  logic [LEN_W-1:0] record_length,
    output logic             push,
    input  logic             push_ready,
    output job_t             push_job
);
    localparam int PW   = $clog2(PAGES);
    localparam int OW   = $clog2(PAGE_BYTES + HDR_BYTES);
    localparam int SUMW = ((OW > LEN_W) ? OW : LEN_W) + 1;

    logic [PW-1:0]    page_reg, page_next;
    logic [OW-1:0]    offset_reg, offset_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;

    logic             accept;
    logic             bad_len;
    logic             wrap;
    logic [PW-1:0]    np;
    logic [OW-1:0]    base_off;
    logic [SUMW-1:0]  fit_sum;
    logic [SUMW-1:0]  rounded;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && push_ready;
    assign push     = accept;

    always_comb begin
        fit_sum  = SUMW'(offset_reg) + SUMW'(record_length);
        bad_len  = (record_length == '0) ||
                   (SUMW'(record_length) > SUMW'(PAGE_BYTES - HDR_BYTES));
        wrap     = fit_sum > SUMW'(PAGE_BYTES);
        np       = (page_reg == PW'(PAGES - 1)) ? '0 : page_reg + PW'(1);
        base_off = wrap ? OW'(HDR_BYTES) : offset_reg;
        rounded  = (SUMW'(base_off) + SUMW'(record_length) + SUMW'(3)) & ~SUMW'(3);

        page_next   = page_reg;
        offset_next = offset_reg;
        seq_next    = seq_reg;

        push_job.kind = JOB_DATA;
        push_job.page = PAGE_MAX_W'(page_reg);
        push_job.seq  = seq_reg;
        push_job.off  = OFF_MAX_W'(offset_reg);
        push_job.len  = record_length;

        if (req_type == REQ_FORMAT) begin
            push_job.kind = JOB_FORMAT;
            page_next     = '0;
            offset_next   = OW'(HDR_BYTES);
            seq_next      = RESET_SEQ;
        end else if (bad_len) begin
            push_job.kind = JOB_REJECT;
        end else begin
            if (wrap) begin
                push_job.kind = JOB_WRAP;
                push_job.page = PAGE_MAX_W'(np);
                push_job.off  = OFF_MAX_W'(HDR_BYTES);
                page_next     = np;
                seq_next      = seq_reg + SEQ_W'(1);
            end
            offset_next = OW'(rounded);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg   <= '0;
            offset_reg <= OW'(HDR_BYTES);
            seq_reg    <= RESET_SEQ;
        end else if (accept) begin
            page_reg   <= page_next;
            offset_reg <= offset_next;
            seq_reg    <= seq_next;
        end
    end

    `FLRA_ASSERT_ALWAYS(a_page_range, aclk, aresetn, page_reg < PW'(PAGES - 1) || page_reg == PW'(PAGES - 1), "active page out of range")
    `FLRA_ASSERT_NEXT(a_format_reset, aclk, aresetn, accept && req_type == REQ_FORMAT, page_reg == '0 && offset_reg == OW'(HDR_BYTES) && seq_reg == RESET_SEQ, "format did not reset pointers")

endmodule

// ===== rtl/flra_fifo.sv =====
// Short job queue between front end and back end.
// Holds flra_pkg::job_t entries; depth from flra_pkg::FIFO_DEPTH.
module flra_fifo import flra_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output job_t pop_job
);
    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    job_t          mem_reg [FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = count_reg != CW'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/flra_back.sv =====
// Back end: steps through each job, forms flash commands and addresses,
// drives the registered result channel. Uses flra_pkg.
`include "flash_log_ring_appender_assert.svh"
module flra_back import flra_pkg::*; #(
    parameter int PAGES      = DEF_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [ADDR_W-1:0] region_base,
    input  logic              job_valid,
    input  job_t              job,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output cmd_t              m_cmd,
    output logic [ADDR_W-1:0] m_addr,
    output logic [SEQ_W-1:0]  m_operand,
    output logic              m_last
);
    localparam int SW = $clog2(PAGES + 1);

    job_t              cur_reg;
    logic              cur_valid_reg;
    logic [SW-1:0]     step_reg;

    logic              m_valid_reg;
    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SEQ_W-1:0]  op_reg;
    logic              last_reg;

    logic                  o_free, emit;
    cmd_t                  r_cmd;
    logic [PAGE_MAX_W-1:0] r_page;
    logic [OFF_MAX_W-1:0]  r_off;
    logic [SEQ_W-1:0]      r_op;
    logic                  r_last, r_zero_addr;
    logic [ADDR_W-1:0]     r_addr;

    assign o_free = !m_valid_reg || m_ready;
    assign emit   = cur_valid_reg && o_free;
    assign pop    = job_valid && (!cur_valid_reg || (emit && r_last));

    always_comb begin
        r_cmd       = CMD_DATA;
        r_page      = cur_reg.page;
        r_off       = '0;
        r_op        = '0;
        r_last      = 1'b0;
        r_zero_addr = 1'b0;
        case (cur_reg.kind)
            JOB_FORMAT: begin
                if (step_reg < SW'(PAGES)) begin
                    r_cmd  = CMD_ERASE;
                    r_page = PAGE_MAX_W'(step_reg);
                end else begin
                    r_cmd  = CMD_HEADER;
                    r_page = '0;
                    r_op   = FORMAT_SEQ;
                    r_last = 1'b1;
                end
            end
            JOB_WRAP: begin
                if (step_reg == SW'(0)) begin
                    r_cmd = CMD_ERASE;
                end else if (step_reg == SW'(1)) begin
                    r_cmd = CMD_HEADER;
                    r_op  = cur_reg.seq;
                end else begin
                    r_cmd  = CMD_DATA;
                    r_off  = cur_reg.off;
                    r_op   = SEQ_W'(cur_reg.len);
                    r_last = 1'b1;
                end
            end
            JOB_DATA: begin
                r_cmd  = CMD_DATA;
                r_off  = cur_reg.off;
                r_op   = SEQ_W'(cur_reg.len);
                r_last = 1'b1;
            end
            default: begin
                r_cmd       = CMD_REJECT;
                r_zero_addr = 1'b1;
                r_last      = 1'b1;
            end
        endcase
        r_addr = r_zero_addr ? '0 :
                 region_base + ADDR_W'(r_page) * ADDR_W'(PAGE_BYTES) + ADDR_W'(r_off);
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= job;
        end
        if (emit) begin
            cmd_reg  <= r_cmd;
            addr_reg <= r_addr;
            op_reg   <= r_op;
            last_reg <= r_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                cur_valid_reg <= 1'b1;
                step_reg      <= '0;
            end else if (emit) begin
                if (r_last) begin
                    cur_valid_reg <= 1'b0;
                end
                step_reg <= step_reg + SW'(1);
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_cmd     = cmd_reg;
    assign m_addr    = addr_reg;
    assign m_operand = op_reg;
    assign m_last    = last_reg;

    `FLRA_ASSERT_IMPLIES(a_single_step, aclk, aresetn, cur_valid_reg && (cur_reg.kind == JOB_DATA || cur_reg.kind == JOB_REJECT), step_reg == '0, "single-result job past first step")
    `FLRA_ASSERT_IMPLIES(a_wrap_steps, aclk, aresetn, cur_valid_reg && cur_reg.kind == JOB_WRAP, step_reg <= SW'(2), "wrap job past data step")
    `FLRA_ASSERT_IMPLIES(a_pop_when_free, aclk, aresetn, pop && cur_valid_reg, emit && r_last, "job loaded over unfinished job")

endmodule

// ===== rtl/flash_log_ring_appender.sv =====
// An accepted request's job passes through the job queue to the back-end sequencer.
// Throughput: 1 result per cycle from the sequencer when not stalled; a request yields 1 result
// (append or reject), 3 (page change: erase, header, data) or PAGES+1 (format).
// Requests are accepted every cycle while the 2-entry job queue has room.
// Reset (aresetn low, synchronous): page 0, offset 4, next sequence 2, region_base 0, queue empty.
module flash_log_ring_appender import flra_pkg::*; #(
    parameter int PAGES      = DEF_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [11:0] record_length
    input  logic [0:0]            s_tuser,   // [0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // [31:0] flash_address, [63:32] operand_value
    output logic [1:0]            m_tuser,   // [1:0] command
    output logic                  m_tlast
);
    logic [ADDR_W-1:0] region_base_reg;
    logic              push, push_ready, pop, pop_valid;
    job_t              push_job, pop_job;
    cmd_t              m_cmd;
    logic [ADDR_W-1:0] m_addr;
    logic [SEQ_W-1:0]  m_operand;

    assign pready = 1'b1;
    assign prdata = region_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_base_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr == REG_REGION_BASE) begin
            region_base_reg <= pwdata;
        end
    end

    flra_front #(
        .PAGES      (PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .req_type      (s_tuser[0]),
        .record_length (s_tdata[LEN_W-1:0]),
        .push          (push),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    flra_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job)
    );

    flra_back #(
        .PAGES      (PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .region_base (region_base_reg),
        .job_valid   (pop_valid),
        .job         (pop_job),
        .pop         (pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_cmd       (m_cmd),
        .m_addr      (m_addr),
        .m_operand   (m_operand),
        .m_last      (m_tlast)
    );

    assign m_tdata = {m_operand, m_addr};
    assign m_tuser = m_cmd;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for flash_log_ring_appender: directed table, then random appends
// and formats under several region bases and stall patterns, checked by a local predictor.
// Depends on rtl/flra_pkg.sv and rtl/flash_log_ring_appender.sv.
`timescale 1ns / 100ps

module tb_top;
    import flra_pkg::*;

    localparam int PAGES      = DEF_PAGES;
    localparam int PAGE_BYTES = DEF_PAGE_BYTES;
    localparam int MAX_LEN    = PAGE_BYTES - HDR_BYTES;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] addr;
        logic [31:0] operand;
        logic        last;
    } flash_op_t;

    typedef struct {
        logic        kind;
        logic [11:0] len;
        logic        has_typed;
        flash_op_t   typed_op;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // [11:0] record_length
    logic [0:0]            s_tuser;   // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready;
    logic [63:0]           m_tdata;   // [31:0] flash_address, [63:32] operand_value
    logic [1:0]            m_tuser;   // [1:0] command
    logic                  m_tlast;

    flash_op_t pending_ops[$];
    flash_op_t step_ops[$];

    logic [31:0] region_base_q;
    logic [1:0]  log_page;
    logic [12:0] fill_offset;
    logic [31:0] header_seq;

    int src_idle_pct;
    int sink_stall_pct;
    int mismatches;

    localparam flash_op_t NO_OP = '{CMD_REJECT, 32'd0, 32'd0, 1'b1};

    dir_row_t dir_rows [0:19] = '{
        '{REQ_APPEND, 12'd1,    1'b1, '{CMD_DATA, 32'd4, 32'd1, 1'b1}},
        '{REQ_APPEND, 12'd0,    1'b1, NO_OP},
        '{REQ_APPEND, 12'd4093, 1'b1, NO_OP},
        '{REQ_APPEND, 12'd4095, 1'b1, NO_OP},
        '{REQ_APPEND, 12'd4092, 1'b0, NO_OP},
        '{REQ_APPEND, 12'd2048, 1'b0, NO_OP},
        '{REQ_APPEND, 12'd2047, 1'b0, NO_OP},
        '{REQ_APPEND, 12'd3,    1'b0, NO_OP},
        '{REQ_APPEND, 12'd2040, 1'b0, NO_OP},
        '{REQ_APPEND, 12'd4092, 1'b0, NO_OP},
        '{REQ_APPEND, 12'hAAA,  1'b0, NO_OP},
        '{REQ_APPEND, 12'h555,  1'b0, NO_OP},
        '{REQ_FORMAT, 12'd0,    1'b0, NO_OP},
        '{REQ_APPEND, 12'd4092, 1'b1, '{CMD_DATA, 32'd4, 32'd4092, 1'b1}},
        '{REQ_APPEND, 12'd1,    1'b0, NO_OP},
        '{REQ_FORMAT, 12'hFFF,  1'b0, NO_OP},
        '{REQ_APPEND, 12'd4,    1'b0, NO_OP},
        '{REQ_APPEND, 12'd2,    1'b0, NO_OP},
        '{REQ_APPEND, 12'd4090, 1'b0, NO_OP},
        '{REQ_FORMAT, 12'hABC,  1'b0, NO_OP}
    };

    logic [31:0] cfg_values [0:5] = '{
        32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_E000, 32'h8000_0004, 32'h0, 32'h0
    };

    flash_log_ring_appender #(
        .PAGES      (PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] page_base(input int unsigned page);
        return region_base_q + 32'(page * PAGE_BYTES);
    endfunction

    // Expected command sequence for one request; updates the write pointers.
    task automatic plan_flash_ops(input logic kind, input logic [11:0] len);
        logic [1:0] dest_page;
        step_ops.delete();
        if (kind == REQ_FORMAT) begin
            for (int p = 0; p < PAGES; p++)
                step_ops.push_back('{CMD_ERASE, page_base(p), 32'd0, 1'b0});
            step_ops.push_back('{CMD_HEADER, page_base(0), FORMAT_SEQ, 1'b0});
            log_page    = 2'd0;
            fill_offset = 13'(HDR_BYTES);
            header_seq  = RESET_SEQ;
        end else if (len == 12'd0 || int'(len) > MAX_LEN) begin
            step_ops.push_back('{CMD_REJECT, 32'd0, 32'd0, 1'b0});
        end else begin
            if (int'(fill_offset) + int'(len) > PAGE_BYTES) begin
                dest_page = 2'((int'(log_page) + 1) % PAGES);
                step_ops.push_back('{CMD_ERASE, page_base(dest_page), 32'd0, 1'b0});
                step_ops.push_back('{CMD_HEADER, page_base(dest_page), header_seq, 1'b0});
                header_seq  = header_seq + 32'd1;
                log_page    = dest_page;
                fill_offset = 13'(HDR_BYTES);
            end
            step_ops.push_back('{CMD_DATA, page_base(log_page) + 32'(fill_offset),
                                 32'(len), 1'b0});
            fill_offset = 13'((int'(fill_offset) + int'(len) + 3) & ~3);
        end
        step_ops[step_ops.size()-1].last = 1'b1;
    endtask

    function automatic void report_mismatch(input string what, input flash_op_t exp_op,
                                            input flash_op_t got_op);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): exp cmd=%0d addr=%h op=%h last=%b, got cmd=%0d addr=%h op=%h last=%b",
                     $time, what, exp_op.cmd, exp_op.addr, exp_op.operand, exp_op.last,
                     got_op.cmd, got_op.addr, got_op.operand, got_op.last);
    endfunction

    // One request transfer; expectations are queued at the accepting edge.
    task automatic send_request(input logic kind, input logic [11:0] len,
                                input logic has_typed, input flash_op_t typed_op);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'd0, len};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        plan_flash_ops(kind, len);
        if (has_typed)
            pending_ops.push_back(typed_op);
        else
            foreach (step_ops[i]) pending_ops.push_back(step_ops[i]);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_ops.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [11:0] rand_length();
        int r;
        r = $urandom_range(99);
        if (r < 4)  return 12'd0;
        if (r < 8)  return 12'($urandom_range(4095, MAX_LEN + 1));
        if (r < 45) return 12'($urandom_range(32, 1));
        if (r < 75) return 12'($urandom_range(512, 33));
        if (r < 92) return 12'($urandom_range(2048, 513));
        return 12'($urandom_range(MAX_LEN, 2049));
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin : result_check
        flash_op_t got_op;
        flash_op_t exp_op;
        if (aresetn && m_tvalid && m_tready) begin
            got_op = '{cmd_t'(m_tuser), m_tdata[31:0], m_tdata[63:32], m_tlast};
            if (pending_ops.size() == 0) begin
                report_mismatch("unexpected transfer", NO_OP, got_op);
            end else begin
                exp_op = pending_ops.pop_front();
                if (m_tuser !== exp_op.cmd || m_tdata[31:0] !== exp_op.addr ||
                    m_tdata[63:32] !== exp_op.operand || m_tlast !== exp_op.last)
                    report_mismatch("field", exp_op, got_op);
            end
        end
    end

    initial begin
        logic [31:0] rd;
        logic [31:0] base;
        logic        kind;
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        mismatches     = 0;
        region_base_q  = 32'd0;
        log_page       = 2'd0;
        fill_offset    = 13'(HDR_BYTES);
        header_seq     = RESET_SEQ;
        cfg_values[4]  = $urandom;
        cfg_values[5]  = $urandom;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].kind, dir_rows[i].len, dir_rows[i].has_typed,
                         dir_rows[i].typed_op);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            repeat (4) @(posedge aclk);
            base = cfg_values[ph];
            apb_access(1'b1, REG_REGION_BASE, base, rd);
            region_base_q = base;
            apb_access(1'b0, REG_REGION_BASE, 32'd0, rd);
            if (rd !== base) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t mismatch: region_base read exp %h got %h", $time, base, rd);
            end
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
                default: begin src_idle_pct = 13; sink_stall_pct = 13; end
            endcase
            for (int i = 0; i < 78; i++) begin
                if ($urandom_range(39) == 0)
                    drain();
                kind = ($urandom_range(99) < 5) ? REQ_FORMAT : REQ_APPEND;
                send_request(kind, (kind == REQ_FORMAT) ? 12'($urandom) : rand_length(),
                             1'b0, NO_OP);
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_ops.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
